// ===== src/tpc_pkg.sv =====
// shared constants, codes and types of the transpose-priority cache
// used by tpc_store, tpc_slots and transpose_priority_cache_policy_core
`default_nettype none

package tpc_pkg;

	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 64;
	localparam int SLOT_W   = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);

	localparam int MODE_W   = 2;
	localparam int KEY_W    = 64;
	localparam int VALUE_W  = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int IN_W     = KEY_W + VALUE_W;
	localparam int OUT_F_W  = VALUE_W + KEY_W + COUNT_W;
	localparam int OUT_W    = ((OUT_F_W + 7) / 8) * 8;

	localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_USE      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EVICT    = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_DUP   = 3'd4;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [VALUE_W-1:0]  value;
	} entry_t;

	typedef struct packed {
		logic              ent_we;
		logic [SLOT_W-1:0] ent_waddr;
		entry_t            ent_wdata;
		logic [SLOT_W-1:0] ent_raddr;
		logic              rank_we;
		logic [SLOT_W-1:0] rank_waddr;
		logic [SLOT_W-1:0] rank_wdata;
		logic [SLOT_W-1:0] rank_raddr;
	} store_req_t;

	typedef struct packed {
		logic              set;
		logic [SLOT_W-1:0] set_idx;
		logic              clr;
		logic [SLOT_W-1:0] clr_idx;
	} slot_upd_t;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_SCAN    = 11'b000_0000_0010,
		S_REG_WR  = 11'b000_0000_0100,
		S_SWAP_RD = 11'b000_0000_1000,
		S_SWAP_WA = 11'b000_0001_0000,
		S_SWAP_WB = 11'b000_0010_0000,
		S_EV_RANK = 11'b000_0100_0000,
		S_EV_ENT  = 11'b000_1000_0000,
		S_EV_DATA = 11'b001_0000_0000,
		S_SHIFT   = 11'b010_0000_0000,
		S_RESP    = 11'b100_0000_0000
	} state_t;

endpackage

`default_nettype wire

// ===== src/tpc_store.sv =====
// entry memory (key and value per slot) and rank memory (slot per priority position)
// both synchronous with one write and one registered read port; types from tpc_pkg
`default_nettype none

module tpc_store (
	input  wire logic                       clk,
	input  wire tpc_pkg::store_req_t        req,
	output tpc_pkg::entry_t                 ent_rd_q,
	output logic [tpc_pkg::SLOT_W-1:0]      rank_rd_q
);

	tpc_pkg::entry_t             entry_mem [tpc_pkg::ENTRIES];
	logic [tpc_pkg::SLOT_W-1:0]  rank_mem  [tpc_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (req.ent_we) begin
			entry_mem[req.ent_waddr] <= req.ent_wdata;
		end
		ent_rd_q <= entry_mem[req.ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.rank_we) begin
			rank_mem[req.rank_waddr] <= req.rank_wdata;
		end
		rank_rd_q <= rank_mem[req.rank_raddr];
	end

endmodule

`default_nettype wire

// ===== src/tpc_slots.sv =====
// slot occupancy flags and lowest free slot search
// depends on tpc_pkg for the slot count and the update struct
`default_nettype none

module tpc_slots (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tpc_pkg::slot_upd_t           upd,
	output logic [tpc_pkg::ENTRIES-1:0]       valid_q,
	output logic [tpc_pkg::SLOT_W-1:0]        free_slot,
	output logic                              free_ok
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (upd.set) begin
				valid_q[upd.set_idx] <= 1'b1;
			end
			if (upd.clr) begin
				valid_q[upd.clr_idx] <= 1'b0;
			end
		end
	end

	// lowest index wins
	always_comb begin
		free_ok   = 1'b0;
		free_slot = '0;
		for (int i = tpc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok   = 1'b1;
				free_slot = tpc_pkg::SLOT_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/transpose_priority_cache_policy_core.sv =====
// top level of the transpose-priority cache: command sequencer, result register
// depends on tpc_pkg, tpc_store and tpc_slots
`default_nettype none

// Keyed cache of 16 entries kept in priority order. An item (s_tuser = mode) registers a
// key, looks it up and moves a hit one place up, or evicts the lowest-priority entry; one
// result item follows each input item. Items are handled one at a time: register and use
// scan the held entries through the rank memory and then the entry memory, one position
// per cycle; a register then writes the free slot, and a promoting hit swaps two rank
// positions by a read and two writes. Evict reads the bottom entry and shifts the rank
// memory down one position per cycle. The core returns to idle before the next item is
// accepted. Each memory has a single read port. Occupancy flags clear at reset, so no
// clearing pass is needed. A finished result waits in an output register, and the next
// item is taken while it waits.
module transpose_priority_cache_policy_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [tpc_pkg::IN_W-1:0]        s_tdata,   // key, value_handle
	input  wire logic [tpc_pkg::MODE_W-1:0]      s_tuser,   // mode
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [tpc_pkg::OUT_W-1:0]            m_tdata,   // value_out, evicted_key, entry_count
	output logic [tpc_pkg::STATUS_W-1:0]         m_tuser    // status
);

	tpc_pkg::state_t                 state_q;
	logic [tpc_pkg::MODE_W-1:0]      op_q;
	logic [tpc_pkg::KEY_BITS-1:0]    key_q;
	logic [tpc_pkg::VALUE_W-1:0]     val_q;
	logic [tpc_pkg::CNT_W-1:0]       held_q;
	logic [tpc_pkg::CNT_W-1:0]       scan_cnt_q;
	logic                            valid_s1;
	logic [tpc_pkg::SLOT_W-1:0]      pos_s1;
	logic                            valid_s2;
	logic [tpc_pkg::SLOT_W-1:0]      pos_s2;
	logic                            hit_q;
	logic [tpc_pkg::SLOT_W-1:0]      hit_pos_q;
	logic [tpc_pkg::SLOT_W-1:0]      hit_slot_q;
	logic [tpc_pkg::SLOT_W-1:0]      slot_s2;
	logic [tpc_pkg::VALUE_W-1:0]     hit_value_q;
	logic [tpc_pkg::SLOT_W-1:0]      ev_slot_q;
	logic [tpc_pkg::STATUS_W-1:0]    res_status_q;
	logic [tpc_pkg::VALUE_W-1:0]     res_value_q;
	logic [tpc_pkg::KEY_BITS-1:0]    res_key_q;
	logic                            m_tvalid_q;
	logic [tpc_pkg::STATUS_W-1:0]    out_status_q;
	logic [tpc_pkg::VALUE_W-1:0]     out_value_q;
	logic [tpc_pkg::KEY_W-1:0]       out_key_q;
	logic [tpc_pkg::COUNT_W-1:0]     out_count_q;

	tpc_pkg::store_req_t             req;
	tpc_pkg::entry_t                 ent_rd_q;
	logic [tpc_pkg::SLOT_W-1:0]      rank_rd_q;
	tpc_pkg::slot_upd_t              upd;
	logic [tpc_pkg::ENTRIES-1:0]     slot_valid;
	logic [tpc_pkg::SLOT_W-1:0]      free_slot;
	logic                            free_ok;

	logic                            accept;
	logic                            scan_issue;
	logic                            scan_done;
	logic                            shift_done;
	logic                            key_eq;
	logic                            swap_needed;
	logic                            out_free;
	logic [tpc_pkg::SLOT_W-1:0]      hit_pos_nx;

	tpc_store u_store (
		.clk       (clk),
		.req       (req),
		.ent_rd_q  (ent_rd_q),
		.rank_rd_q (rank_rd_q)
	);

	tpc_slots u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.valid_q   (slot_valid),
		.free_slot (free_slot),
		.free_ok   (free_ok)
	);

	assign s_tready    = (state_q == tpc_pkg::S_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign scan_issue  = ((state_q == tpc_pkg::S_SCAN) || (state_q == tpc_pkg::S_SHIFT))
	                     && (scan_cnt_q < held_q);
	assign scan_done   = (state_q == tpc_pkg::S_SCAN) && !scan_issue && !valid_s1 && !valid_s2;
	assign shift_done  = (state_q == tpc_pkg::S_SHIFT) && !scan_issue && !valid_s1;
	assign key_eq      = valid_s2 && (ent_rd_q.key == key_q);
	assign hit_pos_nx  = hit_pos_q + tpc_pkg::SLOT_W'(1);
	assign swap_needed = (tpc_pkg::CNT_W'(hit_pos_q) + tpc_pkg::CNT_W'(1)) < held_q;
	assign out_free    = !m_tvalid_q || m_tready;

	// memory and flag requests
	always_comb begin
		req            = '0;
		upd            = '0;
		req.ent_raddr  = rank_rd_q;
		req.rank_raddr = scan_cnt_q[tpc_pkg::SLOT_W-1:0];
		case (state_q)
			tpc_pkg::S_REG_WR: begin
				req.ent_we          = 1'b1;
				req.ent_waddr       = free_slot;
				req.ent_wdata.key   = key_q;
				req.ent_wdata.value = val_q;
				req.rank_we         = 1'b1;
				req.rank_waddr      = held_q[tpc_pkg::SLOT_W-1:0];
				req.rank_wdata      = free_slot;
				upd.set             = 1'b1;
				upd.set_idx         = free_slot;
			end
			tpc_pkg::S_SWAP_RD: begin
				req.rank_raddr = hit_pos_nx;
			end
			tpc_pkg::S_SWAP_WA: begin
				req.rank_we    = 1'b1;
				req.rank_waddr = hit_pos_q;
				req.rank_wdata = rank_rd_q;
			end
			tpc_pkg::S_SWAP_WB: begin
				req.rank_we    = 1'b1;
				req.rank_waddr = hit_pos_nx;
				req.rank_wdata = hit_slot_q;
			end
			tpc_pkg::S_EV_RANK: begin
				req.rank_raddr = '0;
			end
			tpc_pkg::S_EV_DATA: begin
				upd.clr     = 1'b1;
				upd.clr_idx = ev_slot_q;
			end
			tpc_pkg::S_SHIFT: begin
				// position p read last cycle moves down to p - 1
				req.rank_we    = valid_s1;
				req.rank_waddr = pos_s1 - tpc_pkg::SLOT_W'(1);
				req.rank_wdata = rank_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tpc_pkg::S_IDLE;
			op_q         <= '0;
			key_q        <= '0;
			val_q        <= '0;
			held_q       <= '0;
			scan_cnt_q   <= '0;
			valid_s1     <= 1'b0;
			pos_s1       <= '0;
			valid_s2     <= 1'b0;
			pos_s2       <= '0;
			slot_s2      <= '0;
			hit_q        <= 1'b0;
			hit_pos_q    <= '0;
			hit_slot_q   <= '0;
			hit_value_q  <= '0;
			ev_slot_q    <= '0;
			res_status_q <= tpc_pkg::STAT_OK;
			res_value_q  <= '0;
			res_key_q    <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= tpc_pkg::STAT_OK;
			out_value_q  <= '0;
			out_key_q    <= '0;
			out_count_q  <= '0;
		end else begin
			// scan pipeline: rank read, entry read, compare
			valid_s1 <= scan_issue;
			pos_s1   <= scan_cnt_q[tpc_pkg::SLOT_W-1:0];
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + tpc_pkg::CNT_W'(1);
			end
			valid_s2 <= valid_s1 && (state_q == tpc_pkg::S_SCAN);
			pos_s2   <= pos_s1;
			slot_s2  <= rank_rd_q;
			if (key_eq && !hit_q) begin
				hit_q       <= 1'b1;
				hit_pos_q   <= pos_s2;
				hit_slot_q  <= slot_s2;
				hit_value_q <= ent_rd_q.value;
			end

			if ((state_q == tpc_pkg::S_RESP) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				tpc_pkg::S_IDLE: begin
					if (accept) begin
						op_q         <= s_tuser;
						key_q        <= s_tdata[tpc_pkg::KEY_BITS-1:0];
						val_q        <= s_tdata[tpc_pkg::KEY_W +: tpc_pkg::VALUE_W];
						hit_q        <= 1'b0;
						scan_cnt_q   <= '0;
						res_status_q <= tpc_pkg::STAT_OK;
						res_value_q  <= '0;
						res_key_q    <= '0;
						case (s_tuser)
							tpc_pkg::MODE_REGISTER: begin
								if (held_q >= tpc_pkg::CNT_W'(tpc_pkg::ENTRIES)) begin
									res_status_q <= tpc_pkg::STAT_FULL;
									state_q      <= tpc_pkg::S_RESP;
								end else begin
									state_q <= tpc_pkg::S_SCAN;
								end
							end
							tpc_pkg::MODE_USE: begin
								state_q <= tpc_pkg::S_SCAN;
							end
							tpc_pkg::MODE_EVICT: begin
								if (held_q == '0) begin
									res_status_q <= tpc_pkg::STAT_EMPTY;
									state_q      <= tpc_pkg::S_RESP;
								end else begin
									state_q <= tpc_pkg::S_EV_RANK;
								end
							end
							default: begin
								state_q <= tpc_pkg::S_RESP;
							end
						endcase
					end
				end
				tpc_pkg::S_SCAN: begin
					if (scan_done) begin
						if (op_q == tpc_pkg::MODE_REGISTER) begin
							if (hit_q) begin
								res_status_q <= tpc_pkg::STAT_DUP;
								state_q      <= tpc_pkg::S_RESP;
							end else if (free_ok) begin
								state_q <= tpc_pkg::S_REG_WR;
							end else begin
								res_status_q <= tpc_pkg::STAT_FULL;
								state_q      <= tpc_pkg::S_RESP;
							end
						end else if (!hit_q) begin
							res_status_q <= tpc_pkg::STAT_MISS;
							state_q      <= tpc_pkg::S_RESP;
						end else begin
							res_value_q <= hit_value_q;
							state_q     <= swap_needed ? tpc_pkg::S_SWAP_RD : tpc_pkg::S_RESP;
						end
					end
				end
				tpc_pkg::S_REG_WR: begin
					held_q  <= held_q + tpc_pkg::CNT_W'(1);
					state_q <= tpc_pkg::S_RESP;
				end
				tpc_pkg::S_SWAP_RD: begin
					state_q <= tpc_pkg::S_SWAP_WA;
				end
				tpc_pkg::S_SWAP_WA: begin
					state_q <= tpc_pkg::S_SWAP_WB;
				end
				tpc_pkg::S_SWAP_WB: begin
					state_q <= tpc_pkg::S_RESP;
				end
				tpc_pkg::S_EV_RANK: begin
					state_q <= tpc_pkg::S_EV_ENT;
				end
				tpc_pkg::S_EV_ENT: begin
					ev_slot_q <= rank_rd_q;
					state_q   <= tpc_pkg::S_EV_DATA;
				end
				tpc_pkg::S_EV_DATA: begin
					res_key_q   <= ent_rd_q.key;
					res_value_q <= ent_rd_q.value;
					scan_cnt_q  <= tpc_pkg::CNT_W'(1);
					state_q     <= tpc_pkg::S_SHIFT;
				end
				tpc_pkg::S_SHIFT: begin
					if (shift_done) begin
						held_q  <= held_q - tpc_pkg::CNT_W'(1);
						state_q <= tpc_pkg::S_RESP;
					end
				end
				tpc_pkg::S_RESP: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_value_q  <= res_value_q;
						out_key_q    <= tpc_pkg::KEY_W'(res_key_q);
						out_count_q  <= tpc_pkg::COUNT_W'(held_q);
						state_q      <= tpc_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= tpc_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(tpc_pkg::OUT_W - tpc_pkg::OUT_F_W){1'b0}},
	                   out_count_q, out_key_q, out_value_q};

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= tpc_pkg::CNT_W'(tpc_pkg::ENTRIES))
		else $error("entry count above capacity");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpc_pkg::S_IDLE) |-> ($countones(slot_valid) == held_q))
		else $error("occupied slots differ from entry count");

	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		key_eq |-> !hit_q)
		else $error("key held in more than one entry");

	a_resp_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpc_pkg::S_RESP) && m_tvalid_q && !m_tready |=> (state_q == tpc_pkg::S_RESP))
		else $error("result dropped while output register busy");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// testbench for transpose_priority_cache_policy_core: directed table, then random commands
// checked against a shadow copy of the priority cache; needs tpc_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
	import tpc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam int RANDOM_PER_PHASE = 600;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value_out;
		logic [KEY_W-1:0]    evicted_key;
		logic [COUNT_W-1:0]  count;
	} cache_res_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic               typed;
		cache_res_t         want;
	} dir_row_t;

	localparam dir_row_t DIRECTED_ROWS [0:24] = '{
		'{MODE_EVICT, 64'h0, 16'h0, 1'b1, '{STAT_EMPTY, 16'h0, 64'h0, 5'd0}},
		'{MODE_USE, 64'h0, 16'h0, 1'b1, '{STAT_MISS, 16'h0, 64'h0, 5'd0}},
		'{MODE_IGNORED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
			'{STAT_OK, 16'h0, 64'h0, 5'd0}},
		'{MODE_REGISTER, 64'h0, 16'h0, 1'b1, '{STAT_OK, 16'h0, 64'h0, 5'd1}},
		'{MODE_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
			'{STAT_OK, 16'h0, 64'h0, 5'd2}},
		'{MODE_REGISTER, 64'h0, 16'h1234, 1'b1, '{STAT_DUP, 16'h0, 64'h0, 5'd2}},
		'{MODE_USE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1'b1, '{STAT_OK, 16'hFFFF, 64'h0, 5'd2}},
		'{MODE_USE, 64'h0, 16'h0, 1'b1, '{STAT_OK, 16'h0, 64'h0, 5'd2}},
		'{MODE_USE, 64'h8000_0000_0000_0000, 16'h0, 1'b1, '{STAT_MISS, 16'h0, 64'h0, 5'd2}},
		'{MODE_REGISTER, 64'h0000_0000_0000_0001, 16'h0001, 1'b0, '0},
		'{MODE_REGISTER, 64'h0000_0000_0000_0002, 16'h8000, 1'b0, '0},
		'{MODE_REGISTER, 64'h5555_5555_5555_5555, 16'h5555, 1'b0, '0},
		'{MODE_REGISTER, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 1'b0, '0},
		'{MODE_REGISTER, 64'h0123_4567_89AB_CDEF, 16'h0123, 1'b0, '0},
		'{MODE_REGISTER, 64'hFEDC_BA98_7654_3210, 16'hFEDC, 1'b0, '0},
		'{MODE_REGISTER, 64'h8000_0000_0000_0000, 16'h7FFF, 1'b0, '0},
		'{MODE_REGISTER, 64'h7FFF_FFFF_FFFF_FFFF, 16'h00FF, 1'b0, '0},
		'{MODE_REGISTER, 64'hFFFF_FFFF_FFFF_FFFE, 16'hFF00, 1'b0, '0},
		'{MODE_REGISTER, 64'h0000_0001_0000_0000, 16'h0F0F, 1'b0, '0},
		'{MODE_REGISTER, 64'h0000_0000_FFFF_FFFF, 16'hF0F0, 1'b0, '0},
		'{MODE_REGISTER, 64'hFFFF_FFFF_0000_0000, 16'h3C3C, 1'b0, '0},
		'{MODE_REGISTER, 64'h1357_9BDF_0246_8ACE, 16'hC3C3, 1'b0, '0},
		'{MODE_REGISTER, 64'h0F0F_0F0F_0F0F_0F0F, 16'h6996, 1'b0, '0},
		'{MODE_REGISTER, 64'h0000_0000_0000_1111, 16'h1111, 1'b1,
			'{STAT_FULL, 16'h0, 64'h0, 5'd16}},
		'{MODE_EVICT, 64'h0, 16'h0, 1'b1,
			'{STAT_OK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd15}}
	};

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic [MODE_W-1:0]   s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	logic [KEY_W-1:0]   shadow_key [ENTRIES];
	logic [VALUE_W-1:0] shadow_value [ENTRIES];
	logic               shadow_used [ENTRIES];
	int                 shadow_rank [ENTRIES];
	int                 shadow_held;

	cache_res_t       pending_results [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               send_idle_pct;
	int               recv_idle_pct;
	int               hold_left;
	int               fail_count;

	transpose_priority_cache_policy_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic cache_res_t predict_cache(input logic [MODE_W-1:0] mode,
			input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] value);
		cache_res_t res;
		int pos;
		int slot;
		int tmp;
		res = '0;
		pos = -1;
		for (int p = 0; p < shadow_held; p++) begin
			if (pos < 0 && shadow_used[shadow_rank[p]] && shadow_key[shadow_rank[p]] == key)
				pos = p;
		end
		case (mode)
			MODE_REGISTER: begin
				if (shadow_held >= ENTRIES) begin
					res.status = STAT_FULL;
				end else if (pos >= 0) begin
					res.status = STAT_DUP;
				end else begin
					slot = 0;
					while (shadow_used[slot])
						slot++;
					shadow_key[slot] = key;
					shadow_value[slot] = value;
					shadow_used[slot] = 1'b1;
					shadow_rank[shadow_held] = slot;
					shadow_held++;
				end
			end
			MODE_USE: begin
				if (pos < 0) begin
					res.status = STAT_MISS;
				end else begin
					res.value_out = shadow_value[shadow_rank[pos]];
					if (pos + 1 < shadow_held) begin
						tmp = shadow_rank[pos];
						shadow_rank[pos] = shadow_rank[pos + 1];
						shadow_rank[pos + 1] = tmp;
					end
				end
			end
			MODE_EVICT: begin
				if (shadow_held == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					slot = shadow_rank[0];
					res.value_out = shadow_value[slot];
					res.evicted_key = shadow_key[slot];
					shadow_used[slot] = 1'b0;
					for (int p = 1; p < shadow_held; p++)
						shadow_rank[p - 1] = shadow_rank[p];
					shadow_held--;
				end
			end
			default: begin
			end
		endcase
		res.status = (res.status == STAT_OK) ? STAT_OK : res.status;
		res.count = shadow_held[COUNT_W-1:0];
		return res;
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
			input logic [VALUE_W-1:0] value, input logic typed, input cache_res_t want);
		cache_res_t predicted;
		int gap;
		gap = 0;
		s_tvalid <= 1'b1;
		s_tdata <= {value, key};
		s_tuser <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_cache(mode, key, value);
		pending_results.push_back(typed ? want : predicted);
		while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_item(input bit fill_bias);
		int roll;
		int reg_w;
		int evict_w;
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0] key;
		logic [VALUE_W-1:0] value;
		reg_w = fill_bias ? 55 : 20;
		evict_w = fill_bias ? 10 : 40;
		value = VALUE_W'($urandom_range(0, 65535));
		key = {$urandom(), $urandom()};
		roll = $urandom_range(0, 99);
		if (roll < 3)
			mode = MODE_IGNORED;
		else if (roll < 3 + reg_w)
			mode = MODE_REGISTER;
		else if (roll < 3 + reg_w + evict_w)
			mode = MODE_EVICT;
		else
			mode = MODE_USE;
		roll = $urandom_range(0, 99);
		if ((mode == MODE_REGISTER && roll < 90) || (mode == MODE_USE && roll < 85))
			key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (mode == MODE_USE && roll < 92)
			key = key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (64'd1 << $urandom_range(0, 63));
		send_item(mode, key, value, 1'b0, '0);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// result side: check each item, then pick the ready level for the next cycle
	initial begin
		cache_res_t want;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result item with nothing expected: status %0d", m_tuser);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.status) begin
						$error("status expected %0d got %0d", want.status, m_tuser);
						fail_count++;
					end
					if (m_tdata[15:0] !== want.value_out) begin
						$error("value_out expected %h got %h", want.value_out, m_tdata[15:0]);
						fail_count++;
					end
					if (m_tdata[79:16] !== want.evicted_key) begin
						$error("evicted_key expected %h got %h", want.evicted_key, m_tdata[79:16]);
						fail_count++;
					end
					if (m_tdata[84:80] !== want.count) begin
						$error("entry_count expected %0d got %0d", want.count, m_tdata[84:80]);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		fail_count = 0;
		hold_left = 0;
		shadow_held = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_used[i] = 1'b0;
			shadow_rank[i] = 0;
		end
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= MODE_REGISTER;
		send_idle_pct = 31;
		recv_idle_pct = 70;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].value,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			bit fill_bias;
			fill_bias = 1'b1;
			send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 70 : 0;
			recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 31 : 0;
			foreach (key_pool[i])
				key_pool[i] = {$urandom(), $urandom()};
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n % 40 == 0) begin
					fill_bias = $urandom_range(0, 1);
					key_pool[$urandom_range(0, POOL_SIZE - 1)] = {$urandom(), $urandom()};
				end
				// long receiver stall while items keep coming, so the input backs up
				if (phase == 0 && n == 100)
					hold_left = 400;
				send_random_item(fill_bias);
			end
			drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
